// ===== rtl/core/fbpa_pkg.sv =====
// Shared codes, widths and control types of the fixed block pool allocator.
package fbpa_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_BUILD = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Result status codes carried on the output tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_BASE  = 2'd0;
    localparam logic [1:0] CFG_SIZE  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;
    localparam int OUT_ADDR_W = 32;
    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int USED_W   = 22;
    localparam int FCNT_W   = 7;

    localparam logic [SIZE_W-1:0]  SIZE_RESET = 16'd64;
    localparam logic [USED_W-1:0]  USED_MAX   = 22'h3F_FFFF;
    localparam logic [FCNT_W-1:0]  FCNT_MAX   = 7'd127;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic            accept;      // latch key, clear result
        logic            set_st;      // override result status
        logic [ST_W-1:0] st;
        logic            alloc_wr;    // pop, record in use
        logic            scan_start;
        logic            scan_step;
        logic            mv_rd;       // read last in-use entry
        logic            mv_wr;       // fill hole, push key
        logic            bld_start;
        logic            bld_step;
        logic            out_load;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic stk_empty;
        logic iu_empty;
        logic scan_hit;
        logic scan_miss;
        logic bld_done;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/fbpa_ctrl.sv =====
// Sequencing state machine of the fixed block pool allocator.
module fbpa_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [fbpa_pkg::OP_W-1:0] i_op,
    input  fbpa_pkg::t_sts            i_sts,
    output logic                      o_ready,
    output fbpa_pkg::t_cmd            o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_MV_RD = 3'd3;
    localparam logic [2:0] S_MV_WR = 3'd4;
    localparam logic [2:0] S_BUILD = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    case (i_op)
                        fbpa_pkg::OP_ALLOC: begin
                            if (i_sts.stk_empty) begin
                                o_cmd.set_st = 1'b1;
                                o_cmd.st     = fbpa_pkg::ST_EMPTY;
                                n_state      = S_DONE;
                            end else begin
                                n_state      = S_ALLOC;
                            end
                        end
                        fbpa_pkg::OP_FREE: begin
                            if (i_sts.iu_empty) begin
                                o_cmd.set_st = 1'b1;
                                o_cmd.st     = fbpa_pkg::ST_MISS;
                                n_state      = S_DONE;
                            end else begin
                                o_cmd.scan_start = 1'b1;
                                n_state          = S_SCAN;
                            end
                        end
                        fbpa_pkg::OP_BUILD: begin
                            o_cmd.bld_start = 1'b1;
                            n_state         = S_BUILD;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                o_cmd.alloc_wr = 1'b1;
                n_state        = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_hit) begin
                    n_state = S_MV_RD;
                end else if (i_sts.scan_miss) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = fbpa_pkg::ST_MISS;
                    n_state      = S_DONE;
                end
            end
            S_MV_RD: begin
                o_cmd.mv_rd = 1'b1;
                n_state     = S_MV_WR;
            end
            S_MV_WR: begin
                o_cmd.mv_wr = 1'b1;
                n_state     = S_DONE;
            end
            S_BUILD: begin
                if (i_sts.bld_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.bld_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/fbpa_dp.sv =====
// Datapath of the fixed block pool allocator: config, free stack, in-use set, result.
module fbpa_dp #(
    parameter int MAX_CHUNKS = 64,
    parameter int ADDR_BITS  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbpa_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [fbpa_pkg::OUT_ADDR_W-1:0]  i_key,
    input  fbpa_pkg::t_cmd                   i_cmd,
    output fbpa_pkg::t_sts                   o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [fbpa_pkg::OUT_ADDR_W-1:0]  o_addr,
    output logic [fbpa_pkg::ST_W-1:0]        o_status,
    output logic [fbpa_pkg::USED_W-1:0]      o_used,
    output logic [fbpa_pkg::FCNT_W-1:0]      o_free_cnt
);

    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);
    localparam int CW    = (CNT_W > fbpa_pkg::COUNT_W) ? CNT_W : fbpa_pkg::COUNT_W;

    // Configuration
    logic [fbpa_pkg::CFG_W-1:0]   r_base;
    logic [fbpa_pkg::SIZE_W-1:0]  r_size;
    logic [fbpa_pkg::COUNT_W-1:0] r_count;

    // Pool state
    logic [CNT_W-1:0]             r_top;
    logic [CNT_W-1:0]             r_iu_cnt;
    logic [fbpa_pkg::USED_W-1:0]  r_used;
    logic [ADDR_BITS-1:0]         r_stk_mem [MAX_CHUNKS];
    logic [ADDR_BITS-1:0]         r_iu_mem  [MAX_CHUNKS];
    logic [ADDR_BITS-1:0]         r_stk_rd;
    logic [ADDR_BITS-1:0]         r_iu_rd;

    // Operation working registers
    logic [ADDR_BITS-1:0]         r_key;
    logic [CNT_W-1:0]             r_scan_idx;
    logic [CNT_W-1:0]             r_cmp_idx;
    logic                         r_cmp_vld;
    logic [IDX_W-1:0]             r_hit_idx;
    logic [CNT_W-1:0]             r_bld_idx;
    logic [ADDR_BITS-1:0]         r_acc;
    logic [ADDR_BITS-1:0]         r_res_addr;
    logic [fbpa_pkg::ST_W-1:0]    r_status;

    // Output register
    logic                         r_out_vld;
    logic [fbpa_pkg::OUT_ADDR_W-1:0] r_out_addr;
    logic [fbpa_pkg::ST_W-1:0]    r_out_st;
    logic [fbpa_pkg::USED_W-1:0]  r_out_used;
    logic [fbpa_pkg::FCNT_W-1:0]  r_out_fcnt;

    logic [CW-1:0]                w_count_ext;
    logic [CNT_W-1:0]             w_lim;
    logic [CNT_W-1:0]             w_top_m1;
    logic [CNT_W-1:0]             w_iu_last;
    logic [fbpa_pkg::USED_W:0]    w_sum;
    logic [fbpa_pkg::USED_W-1:0]  w_size_u;
    logic [fbpa_pkg::USED_W-1:0]  n_used_add;
    logic [fbpa_pkg::USED_W-1:0]  n_used_sub;
    logic [CW-1:0]                w_top_ext;
    logic [fbpa_pkg::FCNT_W-1:0]  w_fcnt;
    logic                         w_match;
    logic                         w_stk_we;
    logic [IDX_W-1:0]             w_stk_wa;
    logic [ADDR_BITS-1:0]         w_stk_wd;
    logic                         w_iu_we;
    logic [IDX_W-1:0]             w_iu_wa;
    logic [ADDR_BITS-1:0]         w_iu_wd;
    logic [IDX_W-1:0]             w_iu_ra;

    // Chunks built by a rebuild: the register value clipped to the pool depth
    assign w_count_ext = CW'(r_count);
    assign w_lim = (w_count_ext > CW'(MAX_CHUNKS)) ? CNT_W'(MAX_CHUNKS) : CNT_W'(w_count_ext);

    assign w_top_m1  = r_top - CNT_W'(1);
    assign w_iu_last = r_iu_cnt - CNT_W'(1);

    // Saturating used-byte arithmetic
    assign w_sum      = {1'b0, r_used} + (fbpa_pkg::USED_W + 1)'(r_size);
    assign n_used_add = w_sum[fbpa_pkg::USED_W] ? fbpa_pkg::USED_MAX
                                                 : w_sum[fbpa_pkg::USED_W-1:0];
    assign w_size_u   = fbpa_pkg::USED_W'(r_size);
    assign n_used_sub = (r_used > w_size_u) ? (r_used - w_size_u) : '0;

    assign w_top_ext = CW'(r_top);
    assign w_fcnt    = (w_top_ext > CW'(fbpa_pkg::FCNT_MAX)) ? fbpa_pkg::FCNT_MAX
                                                              : fbpa_pkg::FCNT_W'(w_top_ext);

    assign w_match = (r_iu_rd == r_key);

    // Memory port selection
    assign w_stk_we = i_cmd.bld_step | i_cmd.mv_wr;
    assign w_stk_wa = i_cmd.bld_step ? r_bld_idx[IDX_W-1:0] : r_top[IDX_W-1:0];
    assign w_stk_wd = i_cmd.bld_step ? r_acc : r_key;
    assign w_iu_we  = i_cmd.alloc_wr | i_cmd.mv_wr;
    assign w_iu_wa  = i_cmd.alloc_wr ? r_iu_cnt[IDX_W-1:0] : r_hit_idx;
    assign w_iu_wd  = i_cmd.alloc_wr ? r_stk_rd : r_iu_rd;
    assign w_iu_ra  = i_cmd.mv_rd ? w_iu_last[IDX_W-1:0] : r_scan_idx[IDX_W-1:0];

    assign o_sts.stk_empty = (r_top == '0);
    assign o_sts.iu_empty  = (r_iu_cnt == '0);
    assign o_sts.scan_hit  = r_cmp_vld & w_match;
    assign o_sts.scan_miss = r_cmp_vld & ~w_match & (r_cmp_idx == w_iu_last);
    assign o_sts.bld_done  = (r_bld_idx == r_top);
    assign o_sts.out_free  = ~r_out_vld | i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_stk_we) begin
            r_stk_mem[w_stk_wa] <= w_stk_wd;
        end
        r_stk_rd <= r_stk_mem[w_top_m1[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_iu_we) begin
            r_iu_mem[w_iu_wa] <= w_iu_wd;
        end
        r_iu_rd <= r_iu_mem[w_iu_ra];
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_size  <= fbpa_pkg::SIZE_RESET;
            r_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                fbpa_pkg::CFG_BASE:  r_base  <= i_cfg_data;
                fbpa_pkg::CFG_SIZE:  r_size  <= i_cfg_data[fbpa_pkg::SIZE_W-1:0];
                fbpa_pkg::CFG_COUNT: r_count <= i_cfg_data[fbpa_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pool control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top     <= '0;
            r_iu_cnt  <= '0;
            r_used    <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            if (i_cmd.alloc_wr) begin
                r_top    <= w_top_m1;
                r_iu_cnt <= r_iu_cnt + CNT_W'(1);
                r_used   <= n_used_add;
            end
            if (i_cmd.mv_wr) begin
                r_top    <= r_top + CNT_W'(1);
                r_iu_cnt <= w_iu_last;
                r_used   <= n_used_sub;
            end
            if (i_cmd.bld_start) begin
                r_top    <= w_lim;
                r_iu_cnt <= '0;
                r_used   <= '0;
            end
            if (i_cmd.scan_start) begin
                r_cmp_vld <= 1'b0;
            end else if (i_cmd.scan_step) begin
                r_cmp_vld <= (r_scan_idx < r_iu_cnt);
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key      <= ADDR_BITS'(i_key);
            r_res_addr <= '0;
        end
        if (i_cmd.set_st) begin
            r_status <= i_cmd.st;
        end else if (i_cmd.accept) begin
            r_status <= fbpa_pkg::ST_OK;
        end
        if (i_cmd.alloc_wr) begin
            r_res_addr <= r_stk_rd;
        end
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_cmp_idx <= r_scan_idx;
            if (r_scan_idx < r_iu_cnt) begin
                r_scan_idx <= r_scan_idx + CNT_W'(1);
            end
            if (o_sts.scan_hit) begin
                r_hit_idx <= r_cmp_idx[IDX_W-1:0];
            end
        end
        if (i_cmd.bld_start) begin
            r_bld_idx <= '0;
            r_acc     <= ADDR_BITS'(r_base);
        end else if (i_cmd.bld_step) begin
            r_bld_idx <= r_bld_idx + CNT_W'(1);
            r_acc     <= r_acc + ADDR_BITS'(r_size);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_addr <= fbpa_pkg::OUT_ADDR_W'(r_res_addr);
            r_out_st   <= r_status;
            r_out_used <= r_used;
            r_out_fcnt <= w_fcnt;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_addr      = r_out_addr;
    assign o_status    = r_out_st;
    assign o_used      = r_out_used;
    assign o_free_cnt  = r_out_fcnt;

endmodule

// ===== rtl/core/fixed_block_pool_allocator.sv =====
// Top level of the fixed block pool allocator: stream ports, controller and datapath.
// Usage:
//   The input stream carries one operation per transfer: tuser holds the opcode
//   (allocate, free, rebuild, no operation) and tdata the chunk address for a free.
//   The output stream returns exactly one result per operation: tdata holds the
//   allocated address, the used-byte total and the free chunk count; tuser holds
//   the status (ok, pool empty, freed address not in use).
//   Configuration (base address, chunk size, chunk count) goes through a plain write port;
//   user writes it only while the block is idle (not enforced); a rebuild applies it to the pool.
// Operation flow (one operation at a time, input ready only when idle):
//   allocate: pops the free stack and records the chunk in use, then registers the result
//   no operation, an allocate from an empty pool or a free with nothing in use: pool unchanged
//   free: a sequential scan of the in-use set, one entry per cycle through its
//         memory read port; a hit moves the last in-use entry into the hole and pushes
//         the freed address onto the free stack; a miss ends after the last entry in use
//   rebuild: one free stack write per chunk, for min(chunk_count, MAX_CHUNKS) chunks
//   The next operation is taken on the cycle after the result is registered.
// Reset: the free stack and the in-use set are empty, used bytes zero, config at
//   its reset values. No clearing pass is needed.
// Stall: a result held in the output register waits for the receiver; the block
//   still takes the next operation and parks its result until the register frees.
module fixed_block_pool_allocator #(
    parameter int MAX_CHUNKS = 64,
    parameter int ADDR_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Operation stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] address
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] chunk_address, [53:32] used_bytes,
                                        // [60:54] free_count, [63:61] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    fbpa_pkg::t_cmd w_cmd;
    fbpa_pkg::t_sts w_sts;

    logic [fbpa_pkg::OUT_ADDR_W-1:0] w_addr;
    logic [fbpa_pkg::USED_W-1:0]     w_used;
    logic [fbpa_pkg::FCNT_W-1:0]     w_fcnt;

    fbpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_op    (s_axis_tuser),
        .i_sts   (w_sts),
        .o_ready (s_axis_tready),
        .o_cmd   (w_cmd)
    );

    fbpa_dp #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_key       (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_addr      (w_addr),
        .o_status    (m_axis_tuser),
        .o_used      (w_used),
        .o_free_cnt  (w_fcnt)
    );

    // Pack result fields from the lowest bit up, zero fill to 64 bits
    assign m_axis_tdata = {3'b000, w_fcnt, w_used, w_addr};

endmodule

// ===== rtl/core/fbpa_chk.sv =====
// Port-level checker of the fixed block pool allocator and its bind.
module fbpa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] i_m_tdata,
    input logic [1:0]  i_m_tuser
);

    // Result stays put while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result changed under stall");

    // No result right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    // A failed operation never hands out an address
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser == fbpa_pkg::ST_EMPTY || i_m_tuser == fbpa_pkg::ST_MISS)
        |-> i_m_tdata[31:0] == 32'd0)
        else $error("address reported on failed operation");

    // Pool empty means no free chunk left
    a_empty_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tuser == fbpa_pkg::ST_EMPTY |-> i_m_tdata[60:54] == 7'd0)
        else $error("pool empty with free chunks");

    // Status is always one of the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tuser == fbpa_pkg::ST_OK || i_m_tuser == fbpa_pkg::ST_EMPTY
                        || i_m_tuser == fbpa_pkg::ST_MISS))
        else $error("undefined status code");

endmodule

bind fixed_block_pool_allocator fbpa_chk u_fbpa_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

// ===== sim/fixed_block_pool_allocator_tb.sv =====
// Testbench for the fixed block pool allocator: random and directed pool traffic, self-checking.
`timescale 1ns / 1ps

typedef struct {
    logic [fbpa_pkg::OUT_ADDR_W-1:0] chunk_addr;
    logic [fbpa_pkg::ST_W-1:0]       status;
    logic [fbpa_pkg::USED_W-1:0]     used;
    logic [fbpa_pkg::FCNT_W-1:0]     fcnt;
} t_pool_result;

// Shadow of the pool: its own free stack, in-use set and byte total, plus the
// results that the block still owes.
class pool_shadow;
    logic [31:0]                    base;
    logic [fbpa_pkg::SIZE_W-1:0]    size;
    logic [fbpa_pkg::COUNT_W-1:0]   count;
    logic [31:0]       free_stack[$];   // last entry is the top
    logic [31:0]       in_use[$];
    int unsigned       used;
    t_pool_result      owed[$];
    int unsigned       fails;
    int unsigned       n_ops, n_alloc, n_free, n_build, n_nop, n_empty, n_miss, n_results;

    function new();
        base  = '0;
        size  = fbpa_pkg::SIZE_RESET;
        count = '0;
    endfunction

    task report(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        fails++;
    endtask

    function void set_reg(input logic [fbpa_pkg::CFG_IDX_W-1:0] idx,
                          input logic [fbpa_pkg::CFG_W-1:0] data);
        case (idx)
            fbpa_pkg::CFG_BASE:  base  = data;
            fbpa_pkg::CFG_SIZE:  size  = data[fbpa_pkg::SIZE_W-1:0];
            fbpa_pkg::CFG_COUNT: count = data[fbpa_pkg::COUNT_W-1:0];
            default: ;  // unknown index, drop the write
        endcase
    endfunction

    // Advance the shadow pool by one accepted operation and queue its result.
    function void apply_op(input logic [fbpa_pkg::OP_W-1:0] op, input logic [31:0] addr);
        t_pool_result r;
        int           hit;
        int           n;
        r.chunk_addr = '0;
        r.status     = fbpa_pkg::ST_OK;
        n_ops++;
        case (op)
            fbpa_pkg::OP_ALLOC: begin
                n_alloc++;
                if (free_stack.size() == 0) begin
                    r.status = fbpa_pkg::ST_EMPTY;
                    n_empty++;
                end else begin
                    r.chunk_addr = free_stack[free_stack.size() - 1];
                    free_stack.delete(free_stack.size() - 1);
                    in_use.insert(in_use.size(), r.chunk_addr);
                    used = (used + size > int'(fbpa_pkg::USED_MAX)) ?
                           int'(fbpa_pkg::USED_MAX) : used + size;
                end
            end
            fbpa_pkg::OP_FREE: begin
                n_free++;
                hit = -1;
                foreach (in_use[i])
                    if (hit < 0 && in_use[i] == addr) hit = i;
                if (hit < 0) begin
                    r.status = fbpa_pkg::ST_MISS;
                    n_miss++;
                end else begin
                    in_use.delete(hit);
                    if (free_stack.size() < 64) free_stack.insert(free_stack.size(), addr);
                    used = (used > size) ? used - size : 0;
                end
            end
            fbpa_pkg::OP_BUILD: begin
                n_build++;
                n = (count > 64) ? 64 : int'(count);
                free_stack.delete();
                in_use.delete();
                // Chunk addresses wrap at 32 bits
                for (int i = 0; i < n; i++)
                    free_stack.insert(free_stack.size(), base + 32'(i) * 32'(size));
                used = 0;
            end
            default: n_nop++;
        endcase
        r.used = used[fbpa_pkg::USED_W-1:0];
        r.fcnt = (free_stack.size() > int'(fbpa_pkg::FCNT_MAX)) ? fbpa_pkg::FCNT_MAX
                                                               : fbpa_pkg::FCNT_W'(free_stack.size());
        owed.insert(owed.size(), r);
    endfunction

    task check_result(input logic [63:0] data, input logic [1:0] user);
        t_pool_result e;
        n_results++;
        if (owed.size() == 0) begin
            report($sformatf("result %0d with no operation outstanding", n_results));
        end else begin
            e = owed.pop_front();
            if (data[31:0] !== e.chunk_addr)
                report($sformatf("result %0d chunk_address %h, want %h",
                                 n_results, data[31:0], e.chunk_addr));
            if (user !== e.status)
                report($sformatf("result %0d status %0d, want %0d", n_results, user, e.status));
            if (data[53:32] !== e.used)
                report($sformatf("result %0d used_bytes %0d, want %0d",
                                 n_results, data[53:32], e.used));
            if (data[60:54] !== e.fcnt)
                report($sformatf("result %0d free_count %0d, want %0d",
                                 n_results, data[60:54], e.fcnt));
            if (data[63:61] !== 3'b000)
                report($sformatf("result %0d padding bits %b", n_results, data[63:61]));
        end
    endtask

    function int pending();
        return owed.size();
    endfunction
endclass

module fixed_block_pool_allocator_tb;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TARGET_OPS     = 1800;
    localparam logic [fbpa_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind it

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_we      = 1'b0;
    logic [1:0]  i_cfg_index   = '0;
    logic [31:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [31:0] address
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // [31:0] chunk_address, [53:32] used_bytes,
                                       // [60:54] free_count, [63:61] zero
    logic [1:0]  m_axis_tuser;         // [1:0] status

    pool_shadow  shadow;
    bit          rx_smooth;      // receiver always ready
    bit          hold_off_req;   // receiver holds off for a long stretch
    int          settings_used;
    int          quiet_cycles;

    fixed_block_pool_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Check every result transfer and end the run if traffic stops dead
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                shadow.check_result(m_axis_tdata, m_axis_tuser);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, shadow.pending());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, mostly short, sometimes long; one long hold-off on request
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end else if (rx_smooth) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_axis_tready <= 1'b1;
                end else begin
                    m_axis_tready <= 1'b0;
                    stall_left = (r < 96) ? $urandom_range(0, 3) : $urandom_range(10, 50);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one operation and hold it until the transfer; keep valid high when gap is 0
    task automatic send_op(input logic [1:0] op, input logic [31:0] addr, input int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!s_axis_tready);
        shadow.apply_op(op, addr);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every owed result has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (shadow.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        shadow.set_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic directed_op(input logic [1:0] op, input logic [31:0] addr);
        send_op(op, addr, pick_gap());
    endtask

    // Random pool setting; garbage in the unused upper bits must be dropped
    task automatic random_settings();
        int          r;
        logic [15:0] sz;
        logic [6:0]  cnt;
        logic [31:0] b;
        r = $urandom_range(0, 99);
        if (r < 8)       cnt = 7'd0;
        else if (r < 18) cnt = 7'd64;
        else if (r < 25) cnt = 7'($urandom_range(65, 127));
        else if (r < 40) cnt = 7'($urandom_range(17, 63));
        else             cnt = 7'($urandom_range(1, 16));
        r = $urandom_range(0, 99);
        if (r < 25)      sz = 16'($urandom_range(1, 16));
        else if (r < 45) sz = 16'd1 << $urandom_range(0, 15);
        else if (r < 55) sz = 16'hFFFF;
        else             sz = 16'($urandom_range(1, 65535));
        r = $urandom_range(0, 99);
        if (r < 15)      b = 32'hFFFF_FFFF - $urandom_range(0, 4096);
        else if (r < 25) b = 32'h0;
        else             b = $urandom;
        if ($urandom_range(0, 9) != 0) write_reg(fbpa_pkg::CFG_BASE, b);
        if ($urandom_range(0, 9) != 0) write_reg(fbpa_pkg::CFG_SIZE, {16'($urandom), sz});
        write_reg(fbpa_pkg::CFG_COUNT, {25'($urandom), cnt});
        if ($urandom_range(0, 7) == 0) write_reg(CFG_UNUSED, $urandom);
        settings_used++;
    endtask

    // A burst of pool traffic: frees mostly hit live chunks so the pool drains and refills
    task automatic run_phase(input int n_ops, input bit smooth);
        int          w_alloc;
        int          r;
        logic [1:0]  op;
        logic [31:0] addr;
        w_alloc = $urandom_range(30, 65);
        repeat (n_ops) begin
            r    = $urandom_range(0, 99);
            addr = $urandom;
            if (r < w_alloc) begin
                op = fbpa_pkg::OP_ALLOC;
            end else if (r < 88) begin
                op = fbpa_pkg::OP_FREE;
                if (shadow.in_use.size() > 0)
                    addr = shadow.in_use[$urandom_range(0, shadow.in_use.size() - 1)];
            end else if (r < 92) begin
                // Unknown free: random, or a chunk that sits on the free stack
                op = fbpa_pkg::OP_FREE;
                if ($urandom_range(0, 1) && shadow.free_stack.size() > 0)
                    addr = shadow.free_stack[$urandom_range(0, shadow.free_stack.size() - 1)];
            end else if (r < 97) begin
                op = fbpa_pkg::OP_NOP;
            end else begin
                op = fbpa_pkg::OP_BUILD;
            end
            send_op(op, addr, smooth ? 0 : pick_gap());
            if (!smooth && $urandom_range(0, 99) == 0) drain();
        end
        drain();
    endtask

    initial begin
        int phase;
        shadow = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: empty pool, unknown free, no-op, rebuild of zero chunks
        directed_op(fbpa_pkg::OP_ALLOC, 32'h0);
        directed_op(fbpa_pkg::OP_FREE,  32'h0);
        directed_op(fbpa_pkg::OP_NOP,   32'hFFFF_FFFF);
        directed_op(fbpa_pkg::OP_BUILD, 32'h0);
        drain();

        // Wrapping addresses; chunk 0 is a valid allocation
        write_reg(fbpa_pkg::CFG_BASE,  32'hFFFF_FFC0);
        write_reg(fbpa_pkg::CFG_COUNT, 32'hFFFF_FF83);
        directed_op(fbpa_pkg::OP_BUILD, 32'h5555_5555);
        repeat (4) directed_op(fbpa_pkg::OP_ALLOC, 32'hAAAA_AAAA);
        directed_op(fbpa_pkg::OP_FREE, 32'h0000_0000);
        directed_op(fbpa_pkg::OP_FREE, 32'h0000_0000);
        directed_op(fbpa_pkg::OP_FREE, 32'hFFFF_FFC0);
        drain();

        // Zero chunk size gives duplicate addresses; unused index is ignored
        write_reg(fbpa_pkg::CFG_SIZE,  32'hABCD_0000);
        write_reg(fbpa_pkg::CFG_BASE,  32'h1234_5678);
        write_reg(fbpa_pkg::CFG_COUNT, 32'd2);
        write_reg(CFG_UNUSED,          32'hFFFF_FFFF);
        directed_op(fbpa_pkg::OP_BUILD, 32'h0);
        directed_op(fbpa_pkg::OP_ALLOC, 32'h0);
        directed_op(fbpa_pkg::OP_ALLOC, 32'h0);
        repeat (3) directed_op(fbpa_pkg::OP_FREE, 32'h1234_5678);
        drain();

        // Size grown between allocate and free: total clamps at zero
        write_reg(fbpa_pkg::CFG_SIZE, 32'd1);
        directed_op(fbpa_pkg::OP_BUILD, 32'h0);
        directed_op(fbpa_pkg::OP_ALLOC, 32'h0);
        directed_op(fbpa_pkg::OP_ALLOC, 32'h0);
        drain();
        write_reg(fbpa_pkg::CFG_SIZE, 32'h0000_FFFF);
        directed_op(fbpa_pkg::OP_FREE, 32'h1234_5678);
        drain();

        // Oversized count clamps to 64 chunks; drive the byte total into saturation
        write_reg(fbpa_pkg::CFG_BASE,  32'h0);
        write_reg(fbpa_pkg::CFG_COUNT, 32'd127);
        send_op(fbpa_pkg::OP_BUILD, 32'h0, 0);
        repeat (65) send_op(fbpa_pkg::OP_ALLOC, 32'h0, pick_gap());
        drain();
        write_reg(fbpa_pkg::CFG_SIZE, 32'd1);
        send_op(fbpa_pkg::OP_FREE, 32'h0, 0);
        drain();
        write_reg(fbpa_pkg::CFG_SIZE, 32'h0000_FFFF);
        send_op(fbpa_pkg::OP_ALLOC, 32'h0, 0);
        repeat (6) send_op(fbpa_pkg::OP_FREE, shadow.in_use[0], pick_gap());
        drain();
        settings_used = 6;

        // Random phases, each under a fresh setting
        phase = 0;
        while (shadow.n_ops < TARGET_OPS) begin
            random_settings();
            send_op(fbpa_pkg::OP_BUILD, $urandom, 0);
            if (phase == 3) begin
                // Long receiver hold-off while the sender keeps offering
                hold_off_req = 1'b1;
                run_phase($urandom_range(40, 70), 1'b1);
            end else if (phase % 7 == 5) begin
                rx_smooth = 1'b1;
                run_phase($urandom_range(30, 70), 1'b1);
                rx_smooth = 1'b0;
            end else begin
                run_phase($urandom_range(20, 80), 1'b0);
            end
            phase++;
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (shadow.pending() != 0)
            shadow.report($sformatf("%0d results never arrived", shadow.pending()));

        $display("Covered %0d operations under %0d pool settings: %0d allocates, %0d frees,",
                 shadow.n_ops, settings_used, shadow.n_alloc, shadow.n_free);
        $display("  %0d rebuilds, %0d no-ops; %0d empty-pool and %0d unknown-free results",
                 shadow.n_build, shadow.n_nop, shadow.n_empty, shadow.n_miss);
        if (shadow.fails == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ctrl.sv
rtl/core/fbpa_dp.sv
rtl/core/fixed_block_pool_allocator.sv
rtl/core/fbpa_chk.sv
sim/fixed_block_pool_allocator_tb.sv
